// ===== hw/rtl/imdc_pkg.sv =====
`default_nettype none

package imdc_pkg;

    localparam int IMDC_SAMPLE_COUNT = 8;

    localparam int ADC_W  = 10;
    localparam int DIST_W = 8;
    localparam int MV_W   = 12;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 21;
    localparam int MUL_B_W = 14;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int SLOPE_W = 11;
    localparam int NUM_W   = 21;

    localparam logic [MUL_B_W-1:0] MV_SCALE = MUL_B_W'(3300);
    localparam int                 MV_SHIFT = 10;

    // num / 10000 as (num * 1677) >> 24, low by at most one
    localparam logic [MUL_B_W-1:0] RECIP_K     = MUL_B_W'(1677);
    localparam int                 RECIP_SHIFT = 24;
    localparam logic [MUL_B_W-1:0] DIVISOR     = MUL_B_W'(10000);

    localparam logic [MV_W-1:0] BRK_5 = MV_W'(2990);
    localparam logic [MV_W-1:0] BRK_4 = MV_W'(2300);
    localparam logic [MV_W-1:0] BRK_3 = MV_W'(1300);
    localparam logic [MV_W-1:0] BRK_2 = MV_W'(750);
    localparam logic [MV_W-1:0] BRK_1 = MV_W'(510);

    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(160);
    localparam logic [MV_W-1:0]   MV_MAX   = MV_W'(3296);

    typedef struct packed {
        logic [SLOPE_W-1:0] slope;
        logic [NUM_W-1:0]   base;
    } imdc_seg_t;

    typedef struct packed {
        logic start;
        logic ack;
    } imdc_conv_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_WRITE,
        ST_MED,
        ST_MED_WAIT,
        ST_CONV
    } imdc_state_t;

    typedef enum logic [2:0] {
        C_IDLE,
        C_MV,
        C_SLOPE,
        C_NUM,
        C_RECIP,
        C_QUO,
        C_FIX,
        C_DONE
    } imdc_cstate_t;

    // segment of the distance curve, numerator is base - slope * mv
    function automatic imdc_seg_t imdc_segment(input logic [MV_W-1:0] mv);
        imdc_seg_t seg;
        if (mv > BRK_5) begin
            seg.slope = SLOPE_W'(63);
            seg.base  = NUM_W'(256880);
        end
        else if (mv > BRK_4) begin
            seg.slope = SLOPE_W'(44);
            seg.base  = NUM_W'(202220);
        end
        else if (mv > BRK_3) begin
            seg.slope = SLOPE_W'(143);
            seg.base  = NUM_W'(385710);
        end
        else if (mv > BRK_2) begin
            seg.slope = SLOPE_W'(441);
            seg.base  = NUM_W'(730880);
        end
        else if (mv > BRK_1) begin
            seg.slope = SLOPE_W'(1111);
            seg.base  = NUM_W'(1166700);
        end
        else begin
            seg.slope = SLOPE_W'(2000);
            seg.base  = NUM_W'(1600000);
        end
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/imdc_ram.sv =====
`default_nettype none

module imdc_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/imdc_conv.sv =====
`default_nettype none

module imdc_conv
    import imdc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire imdc_conv_ctl_t        ctl,
    input  wire logic [ADC_W-1:0]      median,
    output logic                       done,
    output logic      [DIST_W-1:0]     distance_cm,
    output logic      [MV_W-1:0]       median_mv
);

    imdc_cstate_t state_reg, state_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_reg;

    logic [MV_W-1:0]   mv_reg, mv_next;
    logic [NUM_W-1:0]  base_reg, base_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [DIST_W-1:0] q0_reg, q0_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    imdc_seg_t         seg;
    logic [NUM_W-1:0]  rem;
    logic [DIST_W-1:0] quo;

    assign seg = imdc_segment(mv_reg);
    assign rem = num_reg - prod_reg[NUM_W-1:0];
    assign quo = prod_reg[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // shared multiplier and datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        mv_reg   <= mv_next;
        base_reg <= base_next;
        num_reg  <= num_next;
        q0_reg   <= q0_next;
        dist_reg <= dist_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mul_a      = MUL_A_W'(mv_reg);
        mul_b      = MV_SCALE;
        mv_next    = mv_reg;
        base_next  = base_reg;
        num_next   = num_reg;
        q0_next    = q0_reg;
        dist_next  = dist_reg;
        done       = 1'b0;
        case (state_reg)
            C_IDLE:
            begin
                mul_a = MUL_A_W'(median);
                mul_b = MV_SCALE;
                if (ctl.start)
                begin
                    state_next = C_MV;
                end
            end
            C_MV:
            begin
                mv_next    = prod_reg[MV_SHIFT+MV_W-1:MV_SHIFT];
                state_next = C_SLOPE;
            end
            C_SLOPE:
            begin
                mul_a      = MUL_A_W'(mv_reg);
                mul_b      = MUL_B_W'(seg.slope);
                base_next  = seg.base;
                state_next = C_NUM;
            end
            C_NUM:
            begin
                num_next   = base_reg - prod_reg[NUM_W-1:0];
                state_next = C_RECIP;
            end
            C_RECIP:
            begin
                mul_a      = num_reg;
                mul_b      = RECIP_K;
                state_next = C_QUO;
            end
            C_QUO:
            begin
                q0_next    = quo;
                mul_a      = MUL_A_W'(quo);
                mul_b      = DIVISOR;
                state_next = C_FIX;
            end
            C_FIX:
            begin
                // estimate is at most one low
                if (rem >= NUM_W'(DIVISOR))
                begin
                    dist_next = q0_reg + DIST_W'(1);
                end
                else
                begin
                    dist_next = q0_reg;
                end
                state_next = C_DONE;
            end
            C_DONE:
            begin
                done = 1'b1;
                if (ctl.ack)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    assign distance_cm = dist_reg;
    assign median_mv   = mv_reg;

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (dist_reg <= DIST_MAX))
        else $error("distance out of range");

    a_mv_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mv_reg <= MV_MAX))
        else $error("millivolts out of range");

    a_ack_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ack |-> done)
        else $error("ack without result");

endmodule

`default_nettype wire

// ===== hw/rtl/ir_median_distance_converter.sv =====
`default_nettype none

// channel   dir  handshake            payload
// in        in   in_valid / in_stall  adc_sample[9:0]
// out       out  out_valid / out_stall distance_cm[7:0], median_mv[11:0]
//
// a beat is accepted, then each stored sample that moves up in the sorted ram takes
// a compare step (one ram port pair, one compare per cycle); a frame-closing beat adds
// the median read and the shared multiplier sequence
// in_stall is high from acceptance until the insert (and conversion) is done
// the result sits in an output register, so the next frame fills while it waits;
// a frame-closing beat holds in_stall high while that register is still stalled
// reset clears the sample count and both sequencers; the ram needs no clearing

module ir_median_distance_converter
    import imdc_pkg::*;
#(
    parameter int SAMPLE_COUNT = IMDC_SAMPLE_COUNT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ADC_W-1:0]  adc_sample,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [DIST_W-1:0] distance_cm,
    output logic      [MV_W-1:0]   median_mv
);

    localparam int ADDR_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int CNT_W  = $clog2(SAMPLE_COUNT + 1);
    localparam logic [ADDR_W-1:0] MED_IDX  = ADDR_W'(SAMPLE_COUNT / 2);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(SAMPLE_COUNT);

    imdc_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADC_W-1:0]  v_reg, v_next;
    logic              out_valid_reg, out_valid_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic [MV_W-1:0]   mv_reg, mv_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADC_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ADC_W-1:0]  ram_rdata;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_inc;
    logic [ADDR_W-1:0] pos_m1;
    logic [ADDR_W-1:0] pos_m2;

    imdc_conv_ctl_t    conv_ctl;
    logic              conv_done;
    logic [DIST_W-1:0] conv_dist;
    logic [MV_W-1:0]   conv_mv;

    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign pos_m1  = pos_reg - ADDR_W'(1);
    assign pos_m2  = pos_m1 - ADDR_W'(1);

    imdc_ram #(
        .WIDTH (ADC_W),
        .DEPTH (SAMPLE_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    imdc_conv u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (conv_ctl),
        .median      (ram_rdata),
        .done        (conv_done),
        .distance_cm (conv_dist),
        .median_mv   (conv_mv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        v_reg    <= v_next;
        dist_reg <= dist_next;
        mv_reg   <= mv_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        v_next         = v_reg;
        dist_next      = dist_reg;
        mv_next        = mv_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = v_reg;
        ram_raddr      = cnt_m1[ADDR_W-1:0];
        conv_ctl.start = 1'b0;
        conv_ctl.ack   = 1'b0;
        in_stall       = 1'b1;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    v_next   = adc_sample;
                    pos_next = cnt_reg[ADDR_W-1:0];
                    if (cnt_reg == '0)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                ram_we = 1'b1;
                if (ram_rdata > v_reg)
                begin
                    // shift the larger entry up one slot
                    ram_wdata = ram_rdata;
                    pos_next  = pos_m1;
                    ram_raddr = pos_m2;
                    if (pos_m1 == '0)
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else
                begin
                    if (cnt_inc == CNT_FULL)
                    begin
                        cnt_next   = '0;
                        state_next = ST_MED;
                    end
                    else
                    begin
                        cnt_next   = cnt_inc;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_WRITE:
            begin
                ram_we = 1'b1;
                if (cnt_inc == CNT_FULL)
                begin
                    cnt_next   = '0;
                    state_next = ST_MED;
                end
                else
                begin
                    cnt_next   = cnt_inc;
                    state_next = ST_IDLE;
                end
            end
            ST_MED:
            begin
                ram_raddr  = MED_IDX;
                state_next = ST_MED_WAIT;
            end
            ST_MED_WAIT:
            begin
                conv_ctl.start = 1'b1;
                state_next     = ST_CONV;
            end
            ST_CONV:
            begin
                if (conv_done && (!out_valid_reg || !out_stall))
                begin
                    conv_ctl.ack   = 1'b1;
                    dist_next      = conv_dist;
                    mv_next        = conv_mv;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign distance_cm = dist_reg;
    assign median_mv   = mv_reg;

    a_cnt_below_frame: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_FULL)
        else $error("sample count reached frame size");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (CNT_W'(pos_reg) <= cnt_reg))
        else $error("insert position beyond frame");

    a_out_from_conv: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_CONV))
        else $error("result without conversion");

    a_conv_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        conv_done |-> (state_reg == ST_CONV))
        else $error("conversion finished outside wait state");

endmodule

`default_nettype wire
